@@ hw/rtl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_RESERVED = 2'd3
  } spq_status_t;

  // Command broadcast to every cell for one accepted transaction.
  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
  } spq_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: a chain of slot cells and a result register.
//
//   channel   signals                                          direction
//   command   in_valid in_ready opcode entry_key entry_payload  in
//   result    res_valid res_ready out_valid out_key out_payload
//             entry_count status                               out
//
// For each command every cell compares its key with the new key
// in parallel and moves one step along the chain, so a transaction is taken in
// every cycle in which the result register is empty or being drained.
// A stalled result holds the command channel; reset empties the queue at once.
`default_nettype none
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      opcode,
  input  wire logic [KEY_WIDTH-1:0]            entry_key,
  input  wire logic [PAYLOAD_WIDTH-1:0]        entry_payload,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output logic                                 out_valid,
  output logic [KEY_WIDTH-1:0]                 out_key,
  output logic [PAYLOAD_WIDTH-1:0]             out_payload,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   entry_count,
  output logic [1:0]                           status
);
  import spq_pkg::*;

  localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  logic                     used    [QUEUE_DEPTH];
  logic                     shift   [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0]     key     [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] payload [QUEUE_DEPTH];

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   accept;
  logic                   full;
  logic                   empty;
  spq_ctrl_t              ctrl;
  logic [1:0]             status_next;
  logic                   take;

  assign in_ready = !res_valid || res_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == COUNT_WIDTH'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    ctrl        = '0;
    count_next  = count;
    status_next = ST_OK;
    take        = 1'b0;
    case (spq_op_t'(opcode))
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.rem   = accept;
          take       = 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_CLEAR: begin
        ctrl.clr   = accept;
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     l_used;
    logic                     l_shift;
    logic [KEY_WIDTH-1:0]     l_key;
    logic [PAYLOAD_WIDTH-1:0] l_payload;
    logic                     r_used;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;

    if (i == 0) begin : g_head
      // The head behaves as if a full, non-displaced slot stood to its left.
      assign l_used    = 1'b1;
      assign l_shift   = 1'b0;
      assign l_key     = '0;
      assign l_payload = '0;
    end else begin : g_body
      assign l_used    = used[i-1];
      assign l_shift   = shift[i-1];
      assign l_key     = key[i-1];
      assign l_payload = payload[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_used    = 1'b0;
      assign r_key     = '0;
      assign r_payload = '0;
    end else begin : g_link
      assign r_used    = used[i+1];
      assign r_key     = key[i+1];
      assign r_payload = payload[i+1];
    end

    spq_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .new_key       (entry_key),
      .new_payload   (entry_payload),
      .left_used     (l_used),
      .left_shift    (l_shift),
      .left_key      (l_key),
      .left_payload  (l_payload),
      .right_used    (r_used),
      .right_key     (r_key),
      .right_payload (r_payload),
      .used          (used[i]),
      .shift         (shift[i]),
      .key           (key[i]),
      .payload       (payload[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid   <= take;
      out_key     <= take ? key[0] : '0;
      out_payload <= take ? payload[0] : '0;
      entry_count <= count_next;
      status      <= status_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none
module spq_cell #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire spq_pkg::spq_ctrl_t       ctrl,
  input  wire logic [KEY_WIDTH-1:0]     new_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] new_payload,
  input  wire logic                     left_used,
  input  wire logic                     left_shift,
  input  wire logic [KEY_WIDTH-1:0]     left_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] left_payload,
  input  wire logic                     right_used,
  input  wire logic [KEY_WIDTH-1:0]     right_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] right_payload,
  output logic                          used,
  output logic                          shift,
  output logic [KEY_WIDTH-1:0]          key,
  output logic [PAYLOAD_WIDTH-1:0]      payload
);
  import spq_pkg::*;

  // An entry moves right on insert when its key is strictly greater, so equal
  // keys stay ahead of the newcomer. Empty slots always count as displaced.
  assign shift = !used || (key > new_key);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_shift) begin
        key     <= left_key;
        payload <= left_payload;
      end else if (shift) begin
        key     <= new_key;
        payload <= new_payload;
      end
    end else if (ctrl.rem) begin
      key     <= right_key;
      payload <= right_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clr) begin
      used <= 1'b0;
    end else if (ctrl.ins) begin
      used <= used | left_used;
    end else if (ctrl.rem) begin
      used <= right_used;
    end
  end

endmodule
`default_nettype wire
